// ===== design/rcf_pkg.sv =====
// ----------------------------------------------------------------------------
// rcf_pkg
// shared widths, register indexes, reset values and helpers of the ring clock
// face renderer
// ----------------------------------------------------------------------------
package rcf_pkg;

  // field widths
  localparam int HOURS_W  = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int LIGHT_W  = 10;
  localparam int LED_W    = 6;
  localparam int COLOR_W  = 24;
  localparam int BRIGHT_W = 8;
  localparam int OFFSET_W = 6;
  localparam int HALF_W   = 5;
  localparam int CFG_IDX_W = 3;

  // ring size default
  localparam int RING_LEDS_DEF = 60;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOUR_COLOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTE_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_COLOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RING_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOUR_HALF    = 3'd4;

  // register reset values
  localparam logic [COLOR_W-1:0]  HOUR_COLOR_RST   = 24'hFF0000;
  localparam logic [COLOR_W-1:0]  MINUTE_COLOR_RST = 24'h00FF00;
  localparam logic [COLOR_W-1:0]  SECOND_COLOR_RST = 24'h0000FF;
  localparam logic [OFFSET_W-1:0] RING_OFFSET_RST  = 6'd0;
  localparam logic [HALF_W-1:0]   HOUR_HALF_RST    = 5'd1;

  // brightness mapping and filter
  localparam int HOUR_STEP   = 5;
  localparam int LIGHT_KNEE  = 512;
  localparam int BRIGHT_FULL = 255;
  localparam int BRIGHT_TOP  = 234;
  localparam int BRIGHT_MIN  = 3;
  localparam int DROP_LIMIT  = BRIGHT_TOP - BRIGHT_MIN;
  localparam int FILT_KEEP   = 29;
  localparam int FILT_DIV    = 30;
  localparam int RECIP_SH    = 16;
  localparam logic [16:0] FILT_RECIP = 17'((1 << RECIP_SH) / FILT_DIV);

  typedef logic [COLOR_W-1:0] color_t;

  // x mod n for x below 256, n from 12 to 63; recip is floor(2^16 / n)
  function automatic logic [LED_W-1:0] mod_ring(input logic [7:0] x,
                                                 input logic [6:0] n,
                                                 input logic [16:0] recip);
    logic [24:0] prod;
    logic [7:0]  q;
    logic [14:0] qn;
    logic [7:0]  r;
    prod = 25'(x) * 25'(recip);
    q    = prod[23:16];
    qn   = 15'(q) * 15'(n);
    r    = x - qn[7:0];
    // estimate is short by at most one
    if (r >= {1'b0, n}) r = r - {1'b0, n};
    return r[LED_W-1:0];
  endfunction

endpackage

// ===== design/rcf_if.sv =====
// ----------------------------------------------------------------------------
// rcf_if
// channel interfaces of the ring clock face renderer: time items in, pixel
// items out, register writes
// ----------------------------------------------------------------------------
interface rcf_in_if;
  logic                             valid;
  logic                             ready;
  logic [rcf_pkg::HOURS_W-1:0]      hours;
  logic [rcf_pkg::MIN_W-1:0]        minutes;
  logic [rcf_pkg::SEC_W-1:0]        seconds;
  logic [rcf_pkg::LIGHT_W-1:0]      light_sample;

  modport source (output valid, hours, minutes, seconds, light_sample, input ready);
  modport sink   (input valid, hours, minutes, seconds, light_sample, output ready);
endinterface

interface rcf_out_if;
  logic                             valid;
  logic                             ready;
  logic [rcf_pkg::LED_W-1:0]        led_index;
  logic [rcf_pkg::COLOR_W-1:0]      led_color;
  logic [rcf_pkg::BRIGHT_W-1:0]     brightness;
  logic                             last;

  modport source (output valid, led_index, led_color, brightness, last, input ready);
  modport sink   (input valid, led_index, led_color, brightness, last, output ready);
endinterface

interface rcf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rcf_pkg::CFG_IDX_W-1:0]    index;
  logic [rcf_pkg::COLOR_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ring_clock_face_renderer.sv =====
// ----------------------------------------------------------------------------
// ring_clock_face_renderer
// paints hour, minute and second hands on an LED ring, one pixel item per LED
// ----------------------------------------------------------------------------
// in_ch takes one item per frame: hours, minutes, seconds and a light sample.
// out_ch returns RING_LEDS pixel items per frame in ascending led_index order,
// each with its colour, the smoothed brightness of the frame and last set on
// the final LED. cfg_ch writes the colours, the ring offset and the hour hand
// half width; it is always ready, and the user must see that it is written
// only while the block is idle, which the block itself does not enforce. An
// accepted item sits in the input register and moves to the frame generator
// once the generator is free (hand positions and brightness filter are
// computed on that move); its first pixel then enters the output register
// when out_ch can take it. The generator emits one pixel per cycle while
// out_ch does not stall; the next item waits in the input register while a
// frame is being emitted. When out_ch stalls, the output register holds and
// the generator stops. Reset restores the register defaults, clears the
// brightness filter to zero and drops all pending items.
// ----------------------------------------------------------------------------
module ring_clock_face_renderer #(
  parameter int RING_LEDS = rcf_pkg::RING_LEDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rcf_in_if.sink     in_ch,
  rcf_out_if.source  out_ch,
  rcf_cfg_if.sink    cfg_ch
);

  localparam logic [6:0]  RING_N     = 7'(RING_LEDS);
  localparam logic [16:0] RING_RECIP = 17'((1 << rcf_pkg::RECIP_SH) / RING_LEDS);
  localparam logic [rcf_pkg::LED_W-1:0] LAST_IDX = rcf_pkg::LED_W'(RING_LEDS - 1);

  // configuration
  rcf_pkg::color_t                  hour_color_r, minute_color_r, second_color_r;
  logic [rcf_pkg::OFFSET_W-1:0]     ring_offset_r;
  logic [rcf_pkg::HALF_W-1:0]       hour_half_r;

  // input register
  logic                             pend_valid_r;
  logic [rcf_pkg::HOURS_W-1:0]      pend_hours_r;
  logic [rcf_pkg::MIN_W-1:0]        pend_min_r;
  logic [rcf_pkg::SEC_W-1:0]        pend_sec_r;
  logic [rcf_pkg::LIGHT_W-1:0]      pend_light_r;

  // frame generator
  logic                             act_valid_r;
  logic [rcf_pkg::LED_W-1:0]        idx_r;
  logic [rcf_pkg::LED_W-1:0]        centre_r, min_led_r, sec_led_r;
  logic [rcf_pkg::BRIGHT_W-1:0]     bright_r;

  // output register
  logic                             out_valid_r;
  logic [rcf_pkg::LED_W-1:0]        out_idx_r;
  rcf_pkg::color_t                  out_color_r;
  logic [rcf_pkg::BRIGHT_W-1:0]     out_bright_r;
  logic                             out_last_r;

  logic in_fire, out_take, gen_fire, idx_last, act_free, load;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_color_r   <= rcf_pkg::HOUR_COLOR_RST;
      minute_color_r <= rcf_pkg::MINUTE_COLOR_RST;
      second_color_r <= rcf_pkg::SECOND_COLOR_RST;
      ring_offset_r  <= rcf_pkg::RING_OFFSET_RST;
      hour_half_r    <= rcf_pkg::HOUR_HALF_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rcf_pkg::REG_HOUR_COLOR:   hour_color_r   <= cfg_ch.data;
        rcf_pkg::REG_MINUTE_COLOR: minute_color_r <= cfg_ch.data;
        rcf_pkg::REG_SECOND_COLOR: second_color_r <= cfg_ch.data;
        rcf_pkg::REG_RING_OFFSET:  ring_offset_r  <= cfg_ch.data[rcf_pkg::OFFSET_W-1:0];
        rcf_pkg::REG_HOUR_HALF:    hour_half_r    <= cfg_ch.data[rcf_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake control
  assign out_take    = !out_valid_r || out_ch.ready;
  assign gen_fire    = act_valid_r && out_take;
  assign idx_last    = (idx_r == LAST_IDX);
  assign act_free    = !act_valid_r || (gen_fire && idx_last);
  assign load        = pend_valid_r && act_free;
  assign in_ch.ready = !pend_valid_r || load;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (in_fire) begin
      pend_valid_r <= 1'b1;
    end else if (load) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_hours_r <= in_ch.hours;
      pend_min_r   <= in_ch.minutes;
      pend_sec_r   <= in_ch.seconds;
      pend_light_r <= in_ch.light_sample;
    end
  end

  // hand positions
  logic [7:0]                   hour_sum, min_sum, sec_sum;
  logic [rcf_pkg::LED_W-1:0]    centre_nxt, min_led_nxt, sec_led_nxt;

  always_comb begin
    hour_sum    = 8'(pend_hours_r) * 8'(rcf_pkg::HOUR_STEP) + 8'(ring_offset_r);
    min_sum     = 8'(pend_min_r) + 8'(ring_offset_r);
    sec_sum     = 8'(pend_sec_r) + 8'(ring_offset_r);
    centre_nxt  = rcf_pkg::mod_ring(hour_sum, RING_N, RING_RECIP);
    min_led_nxt = rcf_pkg::mod_ring(min_sum, RING_N, RING_RECIP);
    sec_led_nxt = rcf_pkg::mod_ring(sec_sum, RING_N, RING_RECIP);
  end

  // target brightness and moving average
  logic [7:0]                   drop, target;
  logic [12:0]                  filt_sum, quot_d, filt_rem;
  logic [29:0]                  filt_prod;
  logic [7:0]                   quot;
  logic [rcf_pkg::BRIGHT_W-1:0] bright_nxt;

  always_comb begin
    // above the knee the light sample drops brightness by half its excess
    drop = pend_light_r[8:1];
    if (!pend_light_r[9]) begin
      target = 8'(rcf_pkg::BRIGHT_FULL);
    end else if (drop >= 8'(rcf_pkg::DROP_LIMIT)) begin
      target = 8'(rcf_pkg::BRIGHT_MIN);
    end else begin
      target = 8'(rcf_pkg::BRIGHT_TOP) - drop;
    end
    filt_sum   = 13'(bright_r) * 13'(rcf_pkg::FILT_KEEP) + 13'(target);
    filt_prod  = 30'(filt_sum) * 30'(rcf_pkg::FILT_RECIP);
    quot       = filt_prod[23:16];
    quot_d     = 13'(quot) * 13'(rcf_pkg::FILT_DIV);
    filt_rem   = filt_sum - quot_d;
    bright_nxt = (filt_rem >= 13'(rcf_pkg::FILT_DIV)) ? quot + 8'd1 : quot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
      idx_r       <= '0;
      bright_r    <= '0;
    end else if (load) begin
      act_valid_r <= 1'b1;
      idx_r       <= '0;
      bright_r    <= bright_nxt;
    end else if (gen_fire) begin
      act_valid_r <= !idx_last;
      idx_r       <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      centre_r  <= centre_nxt;
      min_led_r <= min_led_nxt;
      sec_led_r <= sec_led_nxt;
    end
  end

  // pixel colour: second over minute over hour
  logic [6:0]      dist_fwd, dist_back, half_ext;
  logic            hour_lit;
  rcf_pkg::color_t pix_color;

  always_comb begin
    if (idx_r >= centre_r) begin
      dist_fwd = 7'(idx_r) - 7'(centre_r);
    end else begin
      dist_fwd = 7'(idx_r) + RING_N - 7'(centre_r);
    end
    dist_back = RING_N - dist_fwd;
    half_ext  = 7'(hour_half_r);
    hour_lit  = (dist_fwd <= half_ext) || (dist_back <= half_ext);
    if (idx_r == sec_led_r) begin
      pix_color = second_color_r;
    end else if (idx_r == min_led_r) begin
      pix_color = minute_color_r;
    end else if (hour_lit) begin
      pix_color = hour_color_r;
    end else begin
      pix_color = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= act_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_fire) begin
      out_idx_r    <= idx_r;
      out_color_r  <= pix_color;
      out_bright_r <= bright_r;
      out_last_r   <= idx_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.led_index  = out_idx_r;
  assign out_ch.led_color  = out_color_r;
  assign out_ch.brightness = out_bright_r;
  assign out_ch.last       = out_last_r;

  // checks
  a_last_on_final_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_idx_r == LAST_IDX)))
    else $error("last flag does not match final led index");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_fire && !idx_last && !load) |=> (idx_r == $past(idx_r) + 1'b1))
    else $error("led index did not advance by one");

  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (act_valid_r && idx_r == '0))
    else $error("frame load did not restart at led zero");

  a_hold_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r && !act_free) |-> !in_ch.ready)
    else $error("input ready while the pending item cannot move");

endmodule
